### hw/rtl/gasa_pkg.sv
// ---------------------------------------------------------------------------
// gasa_pkg
// Shared types, codes and helpers for the greedy anchor sequence aligner.
// ---------------------------------------------------------------------------
package gasa_pkg;

   localparam logic [1:0] OP_EQ = 2'd0;
   localparam logic [1:0] OP_X  = 2'd1;
   localparam logic [1:0] OP_I  = 2'd2;
   localparam logic [1:0] OP_D  = 2'd3;

   localparam logic [1:0] ACT_WRITE_A = 2'd0;
   localparam logic [1:0] ACT_WRITE_B = 2'd1;
   localparam logic [1:0] ACT_START   = 2'd2;
   localparam logic [1:0] ACT_PULL    = 2'd3;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_SEARCH = 3'd1;
   localparam logic [2:0] PH_GAP_I  = 3'd2;
   localparam logic [2:0] PH_GAP_D  = 3'd3;
   localparam logic [2:0] PH_DIAG   = 3'd4;
   localparam logic [2:0] PH_TAIL_D = 3'd5;
   localparam logic [2:0] PH_TAIL_I = 3'd6;

   localparam logic [1:0] RES_NONE = 2'd0;
   localparam logic [1:0] RES_OP   = 2'd1;
   localparam logic [1:0] RES_DONE = 2'd2;

   localparam logic [13:0] COUNT_MAX = 14'd16383;
   localparam logic [13:0] SPAN_MAX  = 14'd8192;
   localparam logic [13:0] SPAN_HALF = 14'd4096;
   localparam logic [3:0]  RUN_MAX   = 4'd15;

   typedef struct packed {
      logic [12:0] cur_a;
      logic [12:0] cur_b;
      logic [12:0] end_a;
      logic [12:0] end_b;
      logic [12:0] lost_a;
      logic [12:0] lost_b;
      logic [3:0]  run;
      logic [13:0] span_len;
      logic [13:0] span_cnt;
      logic        ins_turn;
      logic [12:0] gap;
      logic [12:0] walk_a;
      logic [12:0] walk_b;
      logic [2:0]  phase;
      logic [13:0] mcnt;
      logic [13:0] icnt;
   } eng_type;

   localparam eng_type ENG_RESET = '{span_len: 14'd1, phase: PH_IDLE, default: '0};

   function automatic logic [13:0] bump(input logic [13:0] c);
      bump = (c < COUNT_MAX) ? 14'(c + 14'd1) : c;
   endfunction

   function automatic eng_type open_gap(input eng_type s);
      eng_type     r;
      logic [12:0] d1;
      logic [12:0] d2;
      r  = s;
      d1 = 13'(s.cur_a - s.lost_a);
      d2 = 13'(s.cur_b - s.lost_b);
      if (d1 < d2) begin
         r.gap    = 13'(d2 - d1);
         r.walk_a = s.lost_a;
         r.walk_b = 13'(s.cur_b - d1);
         r.phase  = PH_GAP_I;
      end else begin
         r.gap    = 13'(d1 - d2);
         r.walk_a = 13'(s.cur_a - d2);
         r.walk_b = s.lost_b;
         r.phase  = PH_GAP_D;
      end
      open_gap = r;
   endfunction

endpackage

### hw/rtl/greedy_anchor_sequence_aligner.sv
// ---------------------------------------------------------------------------
// greedy_anchor_sequence_aligner
// Greedy anchor based aligner of two base sequences with CIGAR output.
// ---------------------------------------------------------------------------
// Usage:
//   Drive a command word on req_* and raise start; it is taken when busy is
//   low. Actions: write a base of sequence a or b (no response), start an
//   alignment over two windows (no response), pull one CIGAR operation. A
//   pull raises busy until its response word appears on rsp_* with rsp_valid
//   for exactly one cycle; the receiver cannot stall.
//   csr_we writes anchor_length from csr_wdata; the user must do so only while
//   the block is idle, which the block itself does not enforce.
// Walk:
//   Every walk step is a memory read then evaluate on the two sequence memories.
//   A pull walks the steps up to the operation returned and the steps that
//   look ahead for the following one (is_last); the state is rolled back
//   after the look ahead. Mismatch skip searches take more steps.
// Reset:
//   Synchronous, active high; clears the walk state and sets anchor_length
//   to 3. Base memories are not cleared.
// ---------------------------------------------------------------------------
module greedy_anchor_sequence_aligner #(
   parameter int MAX_LEN   = 4096,
   parameter int BASE_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [11:0] req_position,
   input  logic [7:0]  req_base,
   input  logic [12:0] req_start_a,
   input  logic [12:0] req_end_a,
   input  logic [12:0] req_start_b,
   input  logic [12:0] req_end_b,
   output logic        rsp_valid,
   output logic [1:0]  rsp_op,
   output logic        rsp_is_last,
   output logic        rsp_empty_res,
   output logic [13:0] rsp_match_total,
   output logic [13:0] rsp_indel_total,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata
);
   import gasa_pkg::*;

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   localparam logic [1:0] C_IDLE  = 2'd0;
   localparam logic [1:0] C_FETCH = 2'd1;
   localparam logic [1:0] C_EVAL  = 2'd2;

   logic [BASE_BITS-1:0] mem_a [MAX_LEN];
   logic [BASE_BITS-1:0] mem_b [MAX_LEN];

   logic [1:0]           ctl_ff, ctl_in;
   logic                 peek_ff, peek_in;
   logic [1:0]           held_ff, held_in;
   eng_type              eng_ff, eng_in;
   eng_type              bak_ff, bak_in;
   logic [3:0]           anchor_ff;
   logic [BASE_BITS-1:0] rda_ff, rdb_ff;
   logic                 oka_ff, okb_ff;
   logic                 vld_ff, vld_in;
   logic [1:0]           op_ff, op_in;
   logic                 last_ff, last_in;
   logic                 empty_ff, empty_in;
   logic [13:0]          mtot_ff, mtot_in;
   logic [13:0]          itot_ff, itot_in;

   logic        accept;
   logic [31:0] wr_ext, ra_ext, rb_ext;
   logic        base_eq;
   eng_type     step_n;
   logic [1:0]  step_res, step_op;

   assign busy   = (ctl_ff != C_IDLE);
   assign accept = start && !busy;
   assign wr_ext = 32'(req_position);
   assign ra_ext = 32'((eng_ff.phase == PH_DIAG) ? eng_ff.walk_a : eng_ff.cur_a);
   assign rb_ext = 32'((eng_ff.phase == PH_DIAG) ? eng_ff.walk_b : eng_ff.cur_b);
   assign base_eq = (oka_ff ? rda_ff : '0) == (okb_ff ? rdb_ff : '0);

   always_ff @(posedge clock) begin
      if (accept && (wr_ext < 32'(MAX_LEN))) begin
         if (req_action == ACT_WRITE_A) mem_a[wr_ext[AW-1:0]] <= req_base[BASE_BITS-1:0];
         if (req_action == ACT_WRITE_B) mem_b[wr_ext[AW-1:0]] <= req_base[BASE_BITS-1:0];
      end
      rda_ff <= mem_a[ra_ext[AW-1:0]];
      rdb_ff <= mem_b[rb_ext[AW-1:0]];
      oka_ff <= ra_ext < 32'(MAX_LEN);
      okb_ff <= rb_ext < 32'(MAX_LEN);
   end

   gasa_step u_step (
      .s       (eng_ff),
      .base_eq (base_eq),
      .anchor  (anchor_ff),
      .n       (step_n),
      .res     (step_res),
      .op      (step_op)
   );

   always_comb begin
      ctl_in   = ctl_ff;
      peek_in  = peek_ff;
      held_in  = held_ff;
      eng_in   = eng_ff;
      bak_in   = bak_ff;
      vld_in   = 1'b0;
      op_in    = op_ff;
      last_in  = last_ff;
      empty_in = empty_ff;
      mtot_in  = mtot_ff;
      itot_in  = itot_ff;
      case (ctl_ff)
         C_IDLE: begin
            if (accept && (req_action == ACT_START)) begin
               eng_in          = '0;
               eng_in.cur_a    = req_start_a;
               eng_in.end_a    = req_end_a;
               eng_in.cur_b    = req_start_b;
               eng_in.end_b    = req_end_b;
               eng_in.lost_a   = req_start_a;
               eng_in.lost_b   = req_start_b;
               eng_in.span_len = 14'd1;
               eng_in.phase    = PH_SEARCH;
            end else if (accept && (req_action == ACT_PULL)) begin
               peek_in = 1'b0;
               ctl_in  = C_FETCH;
            end
         end
         C_FETCH: ctl_in = C_EVAL;
         C_EVAL: begin
            eng_in = step_n;
            ctl_in = C_FETCH;
            if (step_res != RES_NONE) begin
               if (peek_ff) begin
                  eng_in   = bak_ff;
                  vld_in   = 1'b1;
                  op_in    = held_ff;
                  last_in  = (step_res == RES_DONE);
                  empty_in = 1'b0;
                  mtot_in  = bak_ff.mcnt;
                  itot_in  = bak_ff.icnt;
                  ctl_in   = C_IDLE;
               end else if (step_res == RES_DONE) begin
                  vld_in   = 1'b1;
                  op_in    = OP_EQ;
                  last_in  = 1'b0;
                  empty_in = 1'b1;
                  mtot_in  = step_n.mcnt;
                  itot_in  = step_n.icnt;
                  ctl_in   = C_IDLE;
               end else begin
                  held_in = step_op;
                  bak_in  = step_n;
                  peek_in = 1'b1;
               end
            end
         end
         default: ctl_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff    <= C_IDLE;
         peek_ff   <= 1'b0;
         vld_ff    <= 1'b0;
         anchor_ff <= 4'd3;
         eng_ff    <= ENG_RESET;
      end else begin
         ctl_ff  <= ctl_in;
         peek_ff <= peek_in;
         vld_ff  <= vld_in;
         eng_ff  <= eng_in;
         if (csr_we) anchor_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      held_ff  <= held_in;
      bak_ff   <= bak_in;
      op_ff    <= op_in;
      last_ff  <= last_in;
      empty_ff <= empty_in;
      mtot_ff  <= mtot_in;
      itot_ff  <= itot_in;
   end

   assign rsp_valid       = vld_ff;
   assign rsp_op          = op_ff;
   assign rsp_is_last     = last_ff;
   assign rsp_empty_res   = empty_ff;
   assign rsp_match_total = mtot_ff;
   assign rsp_indel_total = itot_ff;

endmodule

### hw/rtl/gasa_step.sv
// ---------------------------------------------------------------------------
// gasa_step
// One step of the alignment walk: next state, and the operation it yields.
// ---------------------------------------------------------------------------
module gasa_step (
   input  gasa_pkg::eng_type s,
   input  logic              base_eq,
   input  logic [3:0]        anchor,
   output gasa_pkg::eng_type n,
   output logic [1:0]        res,
   output logic [1:0]        op
);
   import gasa_pkg::*;

   logic    in_win;
   logic [3:0]  run_inc;
   logic [13:0] cnt_inc;
   eng_type t;

   assign in_win  = (s.cur_a < s.end_a) && (s.cur_b < s.end_b);
   assign run_inc = 4'(s.run + 4'd1);
   assign cnt_inc = 14'(s.span_cnt + 14'd1);

   always_comb begin
      n   = s;
      t   = s;
      res = RES_NONE;
      op  = OP_EQ;
      case (s.phase)
         PH_SEARCH: begin
            if (!in_win) begin
               if (s.run < anchor) n = open_gap(s);
               else n.phase = PH_TAIL_D;
            end else if (base_eq) begin
               t.cur_a = 13'(s.cur_a + 13'd1);
               t.cur_b = 13'(s.cur_b + 13'd1);
               if (s.run >= anchor) begin
                  if (s.run < RUN_MAX) t.run = run_inc;
                  t.mcnt = bump(s.mcnt);
                  res    = RES_OP;
                  op     = OP_EQ;
                  n      = t;
               end else begin
                  t.run = run_inc;
                  if (run_inc == anchor) begin
                     n          = open_gap(t);
                     n.span_len = 14'd1;
                     n.span_cnt = '0;
                     n.ins_turn = 1'b0;
                  end else begin
                     n = t;
                  end
               end
            end else begin
               if (s.run >= anchor) begin
                  n.lost_a = s.cur_a;
                  n.lost_b = s.cur_b;
               end
               if (s.ins_turn) n.cur_b = 13'(s.cur_b + 13'd1);
               else n.cur_a = 13'(s.cur_a + 13'd1);
               n.span_cnt = cnt_inc;
               if (cnt_inc >= s.span_len) begin
                  n.ins_turn = ~s.ins_turn;
                  n.span_cnt = '0;
                  n.span_len = (s.span_len >= SPAN_HALF) ? SPAN_MAX : 14'(s.span_len << 1);
               end
               n.run = '0;
            end
         end
         PH_GAP_I, PH_GAP_D: begin
            if (s.gap == '0) begin
               n.phase = PH_DIAG;
            end else begin
               n.gap  = 13'(s.gap - 13'd1);
               n.icnt = bump(s.icnt);
               res    = RES_OP;
               op     = (s.phase == PH_GAP_I) ? OP_I : OP_D;
            end
         end
         PH_DIAG: begin
            if ((s.walk_a < s.cur_a) && (s.walk_b < s.cur_b)) begin
               n.walk_a = 13'(s.walk_a + 13'd1);
               n.walk_b = 13'(s.walk_b + 13'd1);
               res      = RES_OP;
               if (base_eq) begin
                  n.mcnt = bump(s.mcnt);
                  op     = OP_EQ;
               end else begin
                  n.icnt = bump(s.icnt);
                  op     = OP_X;
               end
            end else begin
               n.phase = in_win ? PH_SEARCH : PH_TAIL_D;
            end
         end
         PH_TAIL_D: begin
            if (s.cur_a < s.end_a) begin
               n.cur_a = 13'(s.cur_a + 13'd1);
               n.icnt  = bump(s.icnt);
               res     = RES_OP;
               op      = OP_D;
            end else begin
               n.phase = PH_TAIL_I;
            end
         end
         PH_TAIL_I: begin
            if (s.cur_b < s.end_b) begin
               n.cur_b = 13'(s.cur_b + 13'd1);
               n.icnt  = bump(s.icnt);
               res     = RES_OP;
               op      = OP_I;
            end else begin
               n.phase = PH_IDLE;
               res     = RES_DONE;
            end
         end
         default: begin
            n.phase = PH_IDLE;
            res     = RES_DONE;
         end
      endcase
   end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the greedy anchor sequence aligner. A queue of
// command words (base writes, starts, pulls, anchor length writes) feeds a
// clocked driver with random idle bursts. An in-bench walker predicts every
// pull response, and a clocked monitor compares each rsp word field by field.
// ---------------------------------------------------------------------------
module tb;
   import gasa_pkg::*;

   localparam int WATCH_LIMIT = 20000;
   localparam int MEM_DEPTH   = 4096;
   localparam int CALM_IDLE   = 200;

   typedef struct {
      bit          is_cfg;
      logic [3:0]  cfg_val;
      logic [1:0]  action;
      logic [11:0] position;
      logic [7:0]  base;
      logic [12:0] sa, ea, sb, eb;
   } word_type;

   typedef struct {
      logic [1:0]  op;
      logic        last;
      logic        empty;
      logic [13:0] mt;
      logic [13:0] it;
   } cigar_word_type;

   typedef struct {
      logic [12:0] ca, cb, ea, eb, la, lb;
      logic [3:0]  run;
      logic [13:0] slen, scnt;
      logic        turn;
      logic [12:0] gap, wa, wb;
      logic [2:0]  ph;
      logic [13:0] mc, ic;
   } walker_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_action = '0;
   logic [11:0] req_position = '0;
   logic [7:0]  req_base = '0;
   logic [12:0] req_start_a = '0;
   logic [12:0] req_end_a = '0;
   logic [12:0] req_start_b = '0;
   logic [12:0] req_end_b = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_op;
   logic        rsp_is_last;
   logic        rsp_empty_res;
   logic [13:0] rsp_match_total;
   logic [13:0] rsp_indel_total;
   logic        csr_we = 1'b0;
   logic [3:0]  csr_wdata = '0;

   greedy_anchor_sequence_aligner dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_position(req_position), .req_base(req_base),
      .req_start_a(req_start_a), .req_end_a(req_end_a),
      .req_start_b(req_start_b), .req_end_b(req_end_b),
      .rsp_valid(rsp_valid), .rsp_op(rsp_op), .rsp_is_last(rsp_is_last),
      .rsp_empty_res(rsp_empty_res), .rsp_match_total(rsp_match_total),
      .rsp_indel_total(rsp_indel_total),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   word_type       pending_words[$];
   cigar_word_type cigar_expected[$];
   word_type       cur;
   logic [7:0]     mem_a [MEM_DEPTH];
   logic [7:0]     mem_b [MEM_DEPTH];
   walker_type     walker;
   logic [3:0]     anchor_len = 4'd3;
   int             errors = 0;
   int             idle_left = 0;
   int             calm = 0;
   int             watch = 0;
   bit             cfg_go = 1'b0;

   function automatic logic [7:0] base_at(input bit sel_b, input logic [12:0] idx);
      if (idx >= MEM_DEPTH) return 8'd0;
      return sel_b ? mem_b[idx[11:0]] : mem_a[idx[11:0]];
   endfunction

   function automatic logic [13:0] sat_inc(input logic [13:0] c);
      return (c < 14'd16383) ? c + 14'd1 : c;
   endfunction

   function automatic void gap_open(inout walker_type w);
      logic [12:0] d1, d2;
      d1 = w.ca - w.la;
      d2 = w.cb - w.lb;
      if (d1 < d2) begin
         w.gap = d2 - d1; w.wa = w.la; w.wb = w.cb - d1; w.ph = PH_GAP_I;
      end else begin
         w.gap = d1 - d2; w.wa = w.ca - d2; w.wb = w.lb; w.ph = PH_GAP_D;
      end
   endfunction

   function automatic bit in_window(input walker_type w);
      return w.ca < w.ea && w.cb < w.eb;
   endfunction

   // walk until one operation emerges; -1 when the alignment is finished
   function automatic int walk_step(inout walker_type w);
      bit eq;
      while (1) begin
         case (w.ph)
            PH_SEARCH: begin
               if (!in_window(w)) begin
                  if (w.run < anchor_len) gap_open(w);
                  else w.ph = PH_TAIL_D;
               end else if (base_at(0, w.ca) == base_at(1, w.cb)) begin
                  w.ca++; w.cb++;
                  if (w.run >= anchor_len) begin
                     if (w.run < 4'd15) w.run++;
                     w.mc = sat_inc(w.mc);
                     return OP_EQ;
                  end
                  w.run++;
                  if (w.run == anchor_len) begin
                     gap_open(w);
                     w.slen = 14'd1; w.scnt = 14'd0; w.turn = 1'b0;
                  end
               end else begin
                  if (w.run >= anchor_len) begin
                     w.la = w.ca; w.lb = w.cb;
                  end
                  if (w.turn) w.cb++;
                  else w.ca++;
                  w.scnt++;
                  if (w.scnt >= w.slen) begin
                     w.turn = ~w.turn;
                     w.scnt = 14'd0;
                     w.slen = (w.slen >= 14'd4096) ? 14'd8192 : w.slen << 1;
                  end
                  w.run = 4'd0;
               end
            end
            PH_GAP_I, PH_GAP_D: begin
               if (w.gap == 13'd0) w.ph = PH_DIAG;
               else begin
                  w.gap--;
                  w.ic = sat_inc(w.ic);
                  return (w.ph == PH_GAP_I) ? OP_I : OP_D;
               end
            end
            PH_DIAG: begin
               if (w.wa < w.ca && w.wb < w.cb) begin
                  eq = base_at(0, w.wa) == base_at(1, w.wb);
                  w.wa++; w.wb++;
                  if (eq) begin
                     w.mc = sat_inc(w.mc);
                     return OP_EQ;
                  end
                  w.ic = sat_inc(w.ic);
                  return OP_X;
               end
               w.ph = in_window(w) ? PH_SEARCH : PH_TAIL_D;
            end
            PH_TAIL_D: begin
               if (w.ca < w.ea) begin
                  w.ca++;
                  w.ic = sat_inc(w.ic);
                  return OP_D;
               end
               w.ph = PH_TAIL_I;
            end
            PH_TAIL_I: begin
               if (w.cb < w.eb) begin
                  w.cb++;
                  w.ic = sat_inc(w.ic);
                  return OP_I;
               end
               w.ph = PH_IDLE;
               return -1;
            end
            default: begin
               w.ph = PH_IDLE;
               return -1;
            end
         endcase
      end
   endfunction

   task automatic apply_word(input word_type w);
      cigar_word_type e;
      walker_type     peek;
      int             op, nxt;
      case (w.action)
         ACT_WRITE_A: mem_a[w.position] = w.base;
         ACT_WRITE_B: mem_b[w.position] = w.base;
         ACT_START: begin
            walker = '{ca: w.sa, ea: w.ea, cb: w.sb, eb: w.eb, la: w.sa, lb: w.sb,
                       run: 4'd0, slen: 14'd1, scnt: 14'd0, turn: 1'b0, gap: 13'd0,
                       wa: 13'd0, wb: 13'd0, ph: PH_SEARCH, mc: 14'd0, ic: 14'd0};
         end
         default: begin
            op = walk_step(walker);
            if (op < 0) begin
               e.op = OP_EQ; e.last = 1'b0; e.empty = 1'b1;
            end else begin
               peek = walker;
               nxt = walk_step(peek);
               e.op = op[1:0]; e.last = (nxt < 0); e.empty = 1'b0;
            end
            e.mt = walker.mc;
            e.it = walker.ic;
            cigar_expected.push_back(e);
         end
      endcase
   endtask

   task automatic report(input string what, input logic [13:0] got, input logic [13:0] want);
      if (errors < 30) $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // drive
   always @(posedge clock) begin
      if (reset) begin
         start  <= 1'b0;
         csr_we <= 1'b0;
      end else begin
         cfg_go = 1'b0;
         if (start && !busy) apply_word(cur);
         calm = (!busy && !rsp_valid && !start) ? calm + 1 : 0;
         if (start && busy) begin
         end else if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (pending_words.size() == 0) begin
            start <= 1'b0;
         end else if (pending_words[0].is_cfg) begin
            start <= 1'b0;
            if (calm >= 4 && cigar_expected.size() == 0) begin
               cur = pending_words.pop_front();
               cfg_go = 1'b1;
               csr_wdata <= cur.cfg_val;
               anchor_len = cur.cfg_val;
               calm = 0;
            end
         end else begin
            cur = pending_words.pop_front();
            req_action   <= cur.action;
            req_position <= cur.position;
            req_base     <= cur.base;
            req_start_a  <= cur.sa;
            req_end_a    <= cur.ea;
            req_start_b  <= cur.sb;
            req_end_b    <= cur.eb;
            start        <= 1'b1;
            if (pending_words.size() > CALM_IDLE && $urandom_range(0, 5) == 0)
               idle_left = $urandom_range(1, 14);
         end
         csr_we <= cfg_go;
      end
   end

   // check
   always @(posedge clock) begin
      cigar_word_type e;
      if (!reset && rsp_valid) begin
         if (cigar_expected.size() == 0) begin
            report("unexpected word", 14'd0, 14'd0);
         end else begin
            e = cigar_expected.pop_front();
            if (rsp_empty_res !== e.empty)
               report("empty_res", 14'(rsp_empty_res), 14'(e.empty));
            if (rsp_op !== e.op) report("op", 14'(rsp_op), 14'(e.op));
            if (rsp_is_last !== e.last) report("is_last", 14'(rsp_is_last), 14'(e.last));
            if (rsp_match_total !== e.mt) report("match_total", rsp_match_total, e.mt);
            if (rsp_indel_total !== e.it) report("indel_total", rsp_indel_total, e.it);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) watch <= 0;
      else watch <= watch + 1;
      if (watch >= WATCH_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic put(input logic [1:0] act, input int pos, input int b);
      word_type w;
      w = '{is_cfg: 0, cfg_val: 0, action: act, position: pos[11:0], base: b[7:0],
            sa: 0, ea: 0, sb: 0, eb: 0};
      pending_words.push_back(w);
   endtask

   task automatic put_cfg(input int v);
      word_type w;
      w = '{is_cfg: 1, cfg_val: v[3:0], action: ACT_PULL, position: 0, base: 0,
            sa: 0, ea: 0, sb: 0, eb: 0};
      pending_words.push_back(w);
   endtask

   task automatic put_align(input int sa, input int ea, input int sb, input int eb,
                            input int pulls);
      word_type w;
      w = '{is_cfg: 0, cfg_val: 0, action: ACT_START, position: 0, base: 0,
            sa: sa[12:0], ea: ea[12:0], sb: sb[12:0], eb: eb[12:0]};
      pending_words.push_back(w);
      repeat (pulls) put(ACT_PULL, 0, 0);
   endtask

   function automatic int nucleotide();
      case ($urandom_range(0, 3))
         0: return 65;
         1: return 67;
         2: return 71;
         default: return 84;
      endcase
   endfunction

   initial begin
      int o, la, lb, shift, n, v;
      int a_bases [64];
      // preload both sequences over the low area and the top of memory
      put(ACT_PULL, 0, 0);
      for (int i = 0; i < 64; i++) begin
         a_bases[i] = nucleotide();
         put(ACT_WRITE_A, i, a_bases[i]);
         put(ACT_WRITE_B, i, ($urandom_range(0, 5) == 0) ? nucleotide() : a_bases[i]);
      end
      for (int i = 4088; i < 4096; i++) begin
         put(ACT_WRITE_A, i, (i == 4095) ? 255 : 0);
         put(ACT_WRITE_B, i, (i == 4095) ? 255 : ((i & 1) ? 0 : 255));
      end
      put_align(0, 20, 0, 24, 46);
      put_align(8191, 0, 4096, 4096, 2);
      put_align(4088, 4096, 4090, 4096, 16);
      put_align(4096, 4096, 0, 4, 6);
      put_cfg(15);
      put_align(0, 30, 2, 30, 60);
      put_cfg(0);
      put_align(0, 16, 0, 16, 34);
      put_cfg(1);
      put_align(4, 20, 0, 12, 30);
      put_cfg(2);
      put_align(0, 12, 3, 12, 6);

      while (pending_words.size() < 1800) begin
         if ($urandom_range(0, 9) == 0) begin
            v = $urandom_range(0, 15);
            put_cfg(v);
         end
         o  = $urandom_range(0, 40);
         la = $urandom_range(0, 23);
         shift = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
         for (int i = 0; i < la; i++) a_bases[i] = nucleotide();
         for (int i = 0; i < la; i++) put(ACT_WRITE_A, o + i, a_bases[i]);
         for (int i = 0; i < la; i++)
            put(ACT_WRITE_B, o + i,
                (i + shift < la && $urandom_range(0, 7) != 0) ? a_bases[i + shift] : nucleotide());
         if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               if ($urandom_range(0, 1)) put(2'($urandom_range(0, 1)), $urandom_range(0, 4095),
                                             $urandom_range(0, 255));
               else put(2'($urandom_range(0, 1)), $urandom_range(0, 63), $urandom_range(0, 255));
            end
         end
         lb = la - shift + $urandom_range(0, 2);
         if (lb < 0) lb = 0;
         if (o + lb > 64) lb = 64 - o;
         n = la + lb + 1 + $urandom_range(0, 1);
         if ($urandom_range(0, 5) == 0) n = $urandom_range(0, n);
         case ($urandom_range(0, 9))
            0: put_align($urandom_range(0, 64), $urandom_range(0, 64),
                         $urandom_range(0, 64), $urandom_range(0, 64), 40);
            1: put_align($urandom_range(4088, 4096), 4096, $urandom_range(4088, 4096), 4096, 18);
            default: put_align(o, o + la, o, o + lb, n);
         endcase
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (pending_words.size() != 0 || start || cigar_expected.size() != 0);
      repeat (40) @(posedge clock);
      if (errors == 0 && cigar_expected.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
